// ===== rtl/fdm_pkg.sv =====
// Shared types, constants and codes of the frame difference motion mask.
package fdm_pkg;

    // Default sizes of the stores
    localparam int HISTORY_DEF    = 4;
    localparam int MAX_PIXELS_DEF = 65536;

    // Register reset values
    localparam logic [7:0]  THRESHOLD_RESET = 8'd25;
    localparam logic [16:0] FRAME_RESET     = 17'd65536;

    // Register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_FRAME     = 1'b1;

    // Gray conversion weights, Q14
    localparam logic [21:0] GRAY_W_BLUE  = 22'd1868;
    localparam logic [21:0] GRAY_W_GREEN = 22'd9617;
    localparam logic [21:0] GRAY_W_RED   = 22'd4899;
    localparam logic [21:0] GRAY_ROUND   = 22'd8192;

    // Strength scale: one in Q16, numerator shift for 2 * marked in Q16
    localparam logic [16:0] STRENGTH_ONE = 17'd65536;
    localparam int          STRENGTH_SHIFT = 17;

    // Width of the weighted difference sums (enough for eight frames)
    localparam int SUM_W = 16;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } fdm_pixel_t;

    typedef struct packed {
        logic        motion;
        logic        frame_end;
        logic [16:0] strength;
    } fdm_result_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [7:0] gray;
        logic       last;
    } fdm_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } fdm_state_t;

endpackage

// ===== rtl/fdm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module fdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/fdm_queue.sv =====
// Two-entry item queue between the front and the back end.
module fdm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_take,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_take && pop_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== rtl/fdm_front.sv =====
// Front end: accepts pixels, converts to gray and tracks the frame position.
module fdm_front #(
    parameter int MAX_PIXELS = fdm_pkg::MAX_PIXELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  fdm_pkg::fdm_pixel_t              pix,
    input  logic [$clog2(MAX_PIXELS+1)-1:0]  len,
    output logic                             push_valid,
    input  logic                             push_stall,
    output fdm_pkg::fdm_job_t                job,
    output logic [$clog2(MAX_PIXELS)-1:0]    push_pos
);
    import fdm_pkg::*;

    localparam int POS_W = $clog2(MAX_PIXELS);
    localparam int LEN_W = $clog2(MAX_PIXELS+1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [21:0]      gray_sum;
    logic             last;
    logic             accept;

    assign pix_stall  = push_stall;
    assign push_valid = pix_valid;
    assign accept     = pix_valid && !push_stall;

    // Weighted gray sum, rounded
    assign gray_sum = GRAY_W_BLUE * 22'(pix.blue) + GRAY_W_GREEN * 22'(pix.green)
                    + GRAY_W_RED * 22'(pix.red) + GRAY_ROUND;

    assign last = ((LEN_W+1)'(pos_reg) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len);

    assign job.gray = gray_sum[21:14];
    assign job.last = last;
    assign push_pos = pos_reg;

    // Advance position, wrap on last pixel
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end
endmodule

// ===== rtl/fdm_back.sv =====
// Back end: difference history, weighted average test, strength division.
module fdm_back #(
    parameter int HISTORY    = fdm_pkg::HISTORY_DEF,
    parameter int MAX_PIXELS = fdm_pkg::MAX_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_take,
    input  fdm_pkg::fdm_job_t               job,
    input  logic [$clog2(MAX_PIXELS)-1:0]   job_pos,
    input  logic [7:0]                      threshold,
    input  logic [$clog2(MAX_PIXELS+1)-1:0] len,
    output logic                            res_valid,
    input  logic                            res_stall,
    output fdm_pkg::fdm_result_t            res
);
    import fdm_pkg::*;

    localparam int POS_W   = $clog2(MAX_PIXELS);
    localparam int LEN_W   = $clog2(MAX_PIXELS+1);
    localparam int SLOT_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int CNT_W   = $clog2(HISTORY+1);
    localparam int TMP_W   = SLOT_W + 2;
    localparam int RING_D  = HISTORY * MAX_PIXELS;
    localparam int RING_AW = $clog2(RING_D);
    localparam int NUM_W   = LEN_W + STRENGTH_SHIFT;
    localparam int DCNT_W  = $clog2(NUM_W);

    fdm_state_t        state_reg, state_next;
    logic [1:0]        warm_reg, warm_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  marked_reg, marked_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [7:0]        gray_reg, gray_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              last_reg, last_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    fdm_result_t       res_reg, res_next;

    logic              warm_ok;
    logic [CNT_W-1:0]  n, n_m1, k_sel;
    logic [TMP_W-1:0]  slot_tmp;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  rd_pos;
    logic [7:0]        prev_gray, ring_data;
    logic [7:0]        diff;
    logic [SUM_W-1:0]  total, wsum, lhs, rhs;
    logic              motion;
    logic              prev_we, ring_we;
    logic [RING_AW-1:0] ring_raddr, ring_waddr;
    logic [LEN_W:0]    rem_sh;
    logic              qbit;
    logic [NUM_W-1:0]  quo_step;

    assign warm_ok = (warm_reg == 2'd2);
    assign n       = (fill_reg < CNT_W'(HISTORY)) ? fill_reg + CNT_W'(1) : CNT_W'(HISTORY);
    assign n_m1    = n - CNT_W'(1);

    // Pick ring slot of weight k_sel + 1, oldest first, newest at head
    assign k_sel    = (state_reg == ST_IDLE) ? '0 : k_reg + CNT_W'(1);
    assign rd_pos   = (state_reg == ST_IDLE) ? job_pos : pos_reg;
    always_comb
    begin
        slot_tmp = TMP_W'(head_reg) + TMP_W'(HISTORY) + TMP_W'(k_sel) - TMP_W'(n_m1);
        if (slot_tmp >= TMP_W'(HISTORY))
        begin
            slot_tmp = slot_tmp - TMP_W'(HISTORY);
        end
        slot = slot_tmp[SLOT_W-1:0];
    end

    assign ring_raddr = RING_AW'(slot) * RING_AW'(MAX_PIXELS) + RING_AW'(rd_pos);
    assign ring_waddr = RING_AW'(head_reg) * RING_AW'(MAX_PIXELS) + RING_AW'(pos_reg);

    // Motion test: round-half-up average above threshold, without division
    assign diff  = (gray_reg > prev_gray) ? gray_reg - prev_gray : prev_gray - gray_reg;
    assign total = sum_reg + SUM_W'(n) * SUM_W'(diff);
    assign wsum  = (SUM_W'(n) * (SUM_W'(n) + SUM_W'(1))) >> 1;
    assign lhs   = (total << 1) + wsum;
    assign rhs   = (wsum << 1) * (SUM_W'(threshold) + SUM_W'(1));
    assign motion = warm_ok && (lhs >= rhs);

    // One restoring division step
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign qbit     = rem_sh >= (LEN_W+1)'(len);
    assign quo_step = {quo_reg[NUM_W-2:0], qbit};

    always_comb
    begin
        state_next  = state_reg;
        warm_next   = warm_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        marked_next = marked_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        gray_next   = gray_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        res_next    = res_reg;
        job_take    = 1'b0;
        prev_we     = 1'b0;
        ring_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Take next item and start reads
                job_take = 1'b1;
                if (job_valid)
                begin
                    gray_next  = job.gray;
                    last_next  = job.last;
                    pos_next   = job_pos;
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (warm_ok && (k_reg < n_m1))
                begin
                    // Accumulate older difference with its weight
                    sum_next = sum_reg + SUM_W'(k_reg + CNT_W'(1)) * SUM_W'(ring_data);
                    k_next   = k_reg + CNT_W'(1);
                end
                else
                begin
                    // Store gray and difference, decide motion
                    prev_we            = 1'b1;
                    ring_we            = warm_ok;
                    marked_next        = marked_reg + LEN_W'(motion);
                    res_next.motion    = motion;
                    res_next.frame_end = last_reg;
                    res_next.strength  = '0;
                    state_next         = ST_OUT;
                    if (last_reg)
                    begin
                        if (warm_ok)
                        begin
                            num_next   = NUM_W'(marked_next) << STRENGTH_SHIFT;
                            quo_next   = '0;
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            warm_next   = warm_reg + 2'd1;
                            marked_next = '0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                // Shift in one numerator bit per cycle
                num_next  = num_reg << 1;
                quo_next  = quo_step;
                rem_next  = qbit ? LEN_W'(rem_sh - (LEN_W+1)'(len)) : rem_sh[LEN_W-1:0];
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(NUM_W-1))
                begin
                    res_next.strength = (quo_step > NUM_W'(STRENGTH_ONE)) ? STRENGTH_ONE
                                                                           : quo_step[16:0];
                    head_next   = (head_reg == SLOT_W'(HISTORY-1)) ? '0 : head_reg + SLOT_W'(1);
                    fill_next   = (fill_reg < CNT_W'(HISTORY)) ? fill_reg + CNT_W'(1) : fill_reg;
                    marked_next = '0;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold result until taken
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            warm_reg   <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
            marked_reg <= '0;
            k_reg      <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            warm_reg   <= warm_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            marked_reg <= marked_next;
            k_reg      <= k_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        gray_reg <= gray_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    fdm_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PIXELS)
    ) u_prev_ram (
        .clk  (clk),
        .we   (prev_we),
        .waddr(pos_reg),
        .wdata(gray_reg),
        .raddr(rd_pos),
        .rdata(prev_gray)
    );

    fdm_ram #(
        .WIDTH(8),
        .DEPTH(RING_D)
    ) u_ring_ram (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(diff),
        .raddr(ring_raddr),
        .rdata(ring_data)
    );
endmodule

// ===== rtl/frame_difference_motion_mask.sv =====
// Frame difference motion mask: accepts BGR pixels in raster order and returns one
// motion bit per pixel, with the frame's motion strength on its last pixel. The front
// end converts each pixel to gray and feeds a two-entry queue; the back end handles
// one pixel at a time. Each pixel averages n = min(frames of history stored + 1,
// HISTORY) stored differences; the difference memory has one read port, so older
// frames are read one per cycle, and none are read in the two warm-up frames. The
// last pixel of each frame after warm-up also runs the bit-serial strength division.
// The gray and difference memories need no clearing after reset.
module frame_difference_motion_mask #(
    parameter int HISTORY    = fdm_pkg::HISTORY_DEF,
    parameter int MAX_PIXELS = fdm_pkg::MAX_PIXELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  fdm_pkg::fdm_pixel_t  pix,
    output logic                 res_valid,
    input  logic                 res_stall,
    output fdm_pkg::fdm_result_t res,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data
);
    import fdm_pkg::*;

    localparam int POS_W = $clog2(MAX_PIXELS);
    localparam int LEN_W = $clog2(MAX_PIXELS+1);
    localparam int CMP_W = (LEN_W > 17) ? LEN_W : 17;
    localparam int JOB_W = $bits(fdm_job_t);
    localparam int Q_W   = POS_W + JOB_W;

    logic [7:0]       threshold_reg, threshold_next;
    logic [16:0]      frame_reg, frame_next;
    logic [LEN_W-1:0] len;
    logic             push_valid, push_stall;
    fdm_job_t         push_job, pop_job;
    logic [POS_W-1:0] push_pos, pop_pos;
    logic             pop_valid, pop_take;
    logic [Q_W-1:0]   pop_data;

    // Register writes
    always_comb
    begin
        threshold_next = threshold_reg;
        frame_next     = frame_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_next = cfg_data[7:0];
                CFG_FRAME:     frame_next     = cfg_data;
                default:       threshold_next = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            frame_reg     <= FRAME_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            frame_reg     <= frame_next;
        end
    end

    // Clamp frame length into 1..MAX_PIXELS
    always_comb
    begin
        if (frame_reg == 17'd0)
        begin
            len = LEN_W'(1);
        end
        else if (CMP_W'(frame_reg) > CMP_W'(MAX_PIXELS))
        begin
            len = LEN_W'(MAX_PIXELS);
        end
        else
        begin
            len = LEN_W'(frame_reg);
        end
    end

    fdm_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .len       (len),
        .push_valid(push_valid),
        .push_stall(push_stall),
        .job       (push_job),
        .push_pos  (push_pos)
    );

    fdm_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_stall(push_stall),
        .push_data ({push_pos, push_job}),
        .pop_valid (pop_valid),
        .pop_take  (pop_take),
        .pop_data  (pop_data)
    );

    assign pop_job = pop_data[JOB_W-1:0];
    assign pop_pos = pop_data[Q_W-1:JOB_W];

    fdm_back #(
        .HISTORY   (HISTORY),
        .MAX_PIXELS(MAX_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_take  (pop_take),
        .job       (pop_job),
        .job_pos   (pop_pos),
        .threshold (threshold_reg),
        .len       (len),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    // Strength only appears on a frame's last pixel
    a_strength_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.frame_end |-> res.strength == 17'd0)
        else $error("strength away from frame end");

    // Strength saturates at one
    a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.strength <= STRENGTH_ONE)
        else $error("strength above one");

    // Position restarts after a frame's last pixel
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_stall && push_job.last |=> push_pos == '0)
        else $error("position did not restart");
`endif
endmodule

// ===== sim/tb_frame_difference_motion_mask.sv =====
// Testbench for the frame difference motion mask: random and directed pixel streams checked
// against a behavioral predictor of gray, weighted history average, mask and strength.
`timescale 1ns / 100ps

module tb_frame_difference_motion_mask;
    import fdm_pkg::*;

    localparam int HIST = 4;
    localparam int MAXP = 65536;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int EXP_DEPTH = 1024;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    fdm_pixel_t  pix;
    logic        res_valid;
    logic        res_stall;
    fdm_result_t res;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;

    frame_difference_motion_mask dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [7:0]  mdl_threshold;
    logic [16:0] mdl_frame;
    logic [7:0]  mdl_prev_gray [int];
    logic [7:0]  mdl_ring [int];
    int unsigned mdl_fill, mdl_head, mdl_warm, mdl_pos, mdl_marked;

    // Ring of expected results, written at input accept, read at result accept
    fdm_result_t expected_results [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          results_seen;
    int          frames_seen;
    int          pixels_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** frame_difference_motion_mask: FAILED **");
            $finish;
        end
    end

    // Random receiver stall
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compute the expected result of one pixel and advance the predictor
    function automatic fdm_result_t predict_pixel(fdm_pixel_t p);
        fdm_result_t r;
        int unsigned len, pos, gray, prev, diff, n, sum, wsum, slot, avg, k, key;
        longint unsigned s;
        len = (mdl_frame == 0) ? 1 : ((mdl_frame > MAXP) ? MAXP : mdl_frame);
        pos = mdl_pos % MAXP;
        gray = (1868 * p.blue + 9617 * p.green + 4899 * p.red + 8192) >> 14;
        r = '0;
        r.frame_end = (pos + 1 >= len);
        if (mdl_warm >= 2)
        begin
            prev = mdl_prev_gray.exists(pos) ? mdl_prev_gray[pos] : 0;
            diff = (gray > prev) ? gray - prev : prev - gray;
            n = (mdl_fill + 1 > HIST) ? HIST : mdl_fill + 1;
            mdl_ring[mdl_head * MAXP + pos] = diff[7:0];
            sum = 0;
            wsum = 0;
            for (k = 0; k < n; k++)
            begin
                slot = (mdl_head + HIST - (n - 1) + k) % HIST;
                key = slot * MAXP + pos;
                sum += (k + 1) * (mdl_ring.exists(key) ? mdl_ring[key] : 0);
                wsum += k + 1;
            end
            avg = (2 * sum + wsum) / (2 * wsum);
            if (avg > mdl_threshold)
            begin
                r.motion = 1'b1;
                mdl_marked++;
            end
        end
        mdl_prev_gray[pos] = gray[7:0];
        if (r.frame_end)
        begin
            if (mdl_warm >= 2)
            begin
                s = (longint'(mdl_marked) * 131072) / len;
                r.strength = (s > 65536) ? 17'd65536 : s[16:0];
                mdl_head = (mdl_head + 1) % HIST;
                if (mdl_fill < HIST)
                    mdl_fill++;
            end
            else
                mdl_warm++;
            mdl_pos = 0;
            mdl_marked = 0;
        end
        else
            mdl_pos = pos + 1;
        return r;
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        fdm_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (exp_wr == exp_rd)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_results[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (res.frame_end)
                    frames_seen++;
                if (res.motion !== want.motion)
                begin
                    $error("motion: expected %0d actual %0d", want.motion, res.motion);
                    errors++;
                end
                if (res.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d actual %0d",
                           want.frame_end, res.frame_end);
                    errors++;
                end
                if (res.strength !== want.strength)
                begin
                    $error("strength: expected %0d actual %0d", want.strength, res.strength);
                    errors++;
                end
            end
        end
    end

    // Send one pixel, with a random gap before it; valid stays high into the next item
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        fdm_pixel_t p;
        p.blue = b;
        p.green = g;
        p.red = r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        expected_results[exp_wr % EXP_DEPTH] = predict_pixel(p);
        exp_wr++;
        pixels_sent++;
    endtask

    // Drop valid, wait until every expectation is met, then a short margin
    task automatic drain();
        pix_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            mdl_threshold = val[7:0];
        else
            mdl_frame = val;
        @(posedge clk);
    endtask

    // Send whole frames of random pixels; mostly still scenes with moving spots
    task automatic send_frames(int nframes, int len);
        int f, i;
        logic [7:0] base;
        for (f = 0; f < nframes; f++)
        begin
            for (i = 0; i < len; i++)
            begin
                base = 8'(i * 37);
                if ($urandom_range(3) == 0)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_pixel(base, base + 8'($urandom_range(3)), base);
            end
        end
    endtask

    // Directed: extremes of every channel on a short frame
    task automatic test_extremes();
        int f;
        write_reg(CFG_FRAME, 17'd4);
        write_reg(CFG_THRESHOLD, 17'd0);
        for (f = 0; f < 5; f++)
        begin
            send_pixel(8'h00, 8'h00, 8'h00);
            send_pixel(8'hFF, 8'hFF, 8'hFF);
            send_pixel((f % 2) ? 8'hFF : 8'h00, 8'h00, 8'h00);
            send_pixel(8'h00, (f % 2) ? 8'hFF : 8'h00, 8'hFF);
        end
        drain();
    endtask

    // Directed: single-pixel frames and maximum threshold
    task automatic test_short_frames();
        write_reg(CFG_FRAME, 17'd1);
        write_reg(CFG_THRESHOLD, 17'd255);
        send_frames(3, 1);
        drain();
        write_reg(CFG_THRESHOLD, 17'd10);
        send_frames(3, 1);
        drain();
    endtask

    // Random frames at several thresholds; frame length never grows
    task automatic test_random(int sidle, int ridle, int len_a, int len_b);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        write_reg(CFG_FRAME, 17'(len_a));
        write_reg(CFG_THRESHOLD, 17'($urandom_range(40)));
        send_frames(3, len_a);
        drain();
        write_reg(CFG_FRAME, 17'(len_b));
        write_reg(CFG_THRESHOLD, 17'($urandom_range(255)));
        send_frames(3, len_b);
        drain();
        write_reg(CFG_THRESHOLD, 17'd0);
        send_frames(2, len_b);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        errors = 0;
        results_seen = 0;
        frames_seen = 0;
        pixels_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mdl_threshold = THRESHOLD_RESET;
        mdl_frame = FRAME_RESET;
        mdl_fill = 0;
        mdl_head = 0;
        mdl_warm = 0;
        mdl_pos = 0;
        mdl_marked = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_random(22, 69, 40, 32);
        test_random(69, 22, 32, 24);
        test_random(0, 0, 24, 16);
        test_extremes();
        test_short_frames();

        drain();
        $display("Sent %0d pixels, checked %0d results over %0d frames,", pixels_sent,
                 results_seen, frames_seen);
        $display("frame lengths 1 to 40, thresholds 0 to 255, three idle profiles.");
        if (errors == 0 && exp_wr == exp_rd)
            $display("** frame_difference_motion_mask: PASSED **");
        else
            $display("** frame_difference_motion_mask: FAILED **");
        $finish;
    end

endmodule
